### hw/rtl/i2c_master_bit_engine_core_defines.svh
// Assertion macros for the I2C master bit engine checker.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define I2CBE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cbe same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define I2CBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cbe next-cycle check failed");

`endif

### hw/rtl/i2cbe_pkg.sv
// Package: types, codes and constants of the I2C master bit engine.
`default_nettype none

package i2cbe_pkg;

    // Opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_SEND  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_TX_A    = 4'd5;
    localparam logic [3:0] PH_TX_B    = 4'd6;
    localparam logic [3:0] PH_TX_C    = 4'd7;
    localparam logic [3:0] PH_WA_A    = 4'd8;
    localparam logic [3:0] PH_WA_B    = 4'd9;
    localparam logic [3:0] PH_WA_POLL = 4'd10;
    localparam logic [3:0] PH_RX_A    = 4'd11;
    localparam logic [3:0] PH_RX_B    = 4'd12;
    localparam logic [3:0] PH_AK_A    = 4'd13;
    localparam logic [3:0] PH_AK_B    = 4'd14;

    // Register indexes
    localparam logic [1:0] REG_ACK_TIMEOUT     = 2'd0;
    localparam logic [1:0] REG_START_STOP_HOLD = 2'd1;
    localparam logic [1:0] REG_BIT_PHASE_TICKS = 2'd2;

    // Register reset values
    localparam logic [7:0] ACK_TIMEOUT_RST     = 8'd50;
    localparam logic [3:0] START_STOP_HOLD_RST = 4'd2;
    localparam logic [3:0] BIT_PHASE_TICKS_RST = 4'd1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_item_t;

    typedef struct packed {
        logic [7:0] ack_timeout;
        logic [3:0] start_stop_hold;
        logic [3:0] bit_phase_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] bit_index;
        logic [7:0] shift_reg;
        logic [3:0] phase_timer;
        logic [7:0] poll_count;
        logic       ack_choice;
        logic       scl;
        logic       sda;
        logic [7:0] rx_last;
        logic       fail;
        logic       stop_from_timeout;
    } eng_state_t;

    // Zero hold acts as one tick.
    function automatic logic [3:0] hold_ticks(input logic [3:0] h);
        return (h == 4'd0) ? 4'd1 : h;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: state, config and output registers.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_data  (i2cbe_pkg::in_item_t), one bus tick
//   m_       out  m_valid/m_ready    m_data  (i2cbe_pkg::out_item_t), one per tick
//   cfg_     in   cfg_we             cfg_index, cfg_wdata (8 bit)
//
// The tick logic in i2cbe_step sits between the engine state register and
// the result register, so one item per cycle while the m_ side takes results.
// m_valid rises in the cycle after an s_ accept.
// s_ready = result register empty or being taken this cycle; a stalled m_
// side stops intake after one waiting result.
// aresetn is synchronous, active low: engine idle, lines released, config at
// its reset values (ack_timeout 50, start_stop_hold 2, bit_phase_ticks 1).
`default_nettype none

module i2c_master_bit_engine_core (
    input  wire                        aclk,
    input  wire                        aresetn,
    // input items
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire i2cbe_pkg::in_item_t   s_data,
    // result items
    output logic                       m_valid,
    input  wire                        m_ready,
    output i2cbe_pkg::out_item_t       m_data,
    // config writes
    input  wire                        cfg_we,
    input  wire [1:0]                  cfg_index,
    input  wire [7:0]                  cfg_wdata
);

    i2cbe_pkg::cfg_t       cfg_reg;
    i2cbe_pkg::eng_state_t st_reg;
    i2cbe_pkg::eng_state_t st_next;
    i2cbe_pkg::out_item_t  res_next;
    i2cbe_pkg::out_item_t  m_data_reg;
    logic                  m_valid_reg;
    logic                  s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Config registers; index 3 is not a register and is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout     <= i2cbe_pkg::ACK_TIMEOUT_RST;
            cfg_reg.start_stop_hold <= i2cbe_pkg::START_STOP_HOLD_RST;
            cfg_reg.bit_phase_ticks <= i2cbe_pkg::BIT_PHASE_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cbe_pkg::REG_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= cfg_wdata;
                i2cbe_pkg::REG_START_STOP_HOLD: cfg_reg.start_stop_hold <= cfg_wdata[3:0];
                i2cbe_pkg::REG_BIT_PHASE_TICKS: cfg_reg.bit_phase_ticks <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    i2cbe_step u_step (
        .st   (st_reg),
        .item (s_data),
        .cfg  (cfg_reg),
        .nx   (st_next),
        .res  (res_next)
    );

    // Engine state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase             <= i2cbe_pkg::PH_IDLE;
            st_reg.bit_index         <= 4'd0;
            st_reg.shift_reg         <= 8'd0;
            st_reg.phase_timer       <= 4'd0;
            st_reg.poll_count        <= 8'd0;
            st_reg.ack_choice        <= 1'b0;
            st_reg.scl               <= 1'b1;
            st_reg.sda               <= 1'b1;
            st_reg.rx_last           <= 8'd0;
            st_reg.fail              <= 1'b0;
            st_reg.stop_from_timeout <= 1'b0;
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/i2cbe_step.sv
// One-tick next-state and result logic of the I2C master bit engine.
`default_nettype none

module i2cbe_step (
    input  wire i2cbe_pkg::eng_state_t st,
    input  wire i2cbe_pkg::in_item_t   item,
    input  wire i2cbe_pkg::cfg_t       cfg,
    output i2cbe_pkg::eng_state_t      nx,
    output i2cbe_pkg::out_item_t       res
);

    always_comb begin
        logic       do_ent;
        logic [3:0] ent;
        logic       done;
        logic [3:0] bit_inc;

        nx      = st;
        do_ent  = 1'b0;
        ent     = i2cbe_pkg::PH_IDLE;
        done    = 1'b0;
        bit_inc = st.bit_index + 4'd1;

        if (st.phase == i2cbe_pkg::PH_IDLE) begin
            nx.bit_index  = 4'd0;
            nx.poll_count = 8'd0;
            unique case (item.opcode)
                i2cbe_pkg::OP_START: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_ST_A;
                end
                i2cbe_pkg::OP_STOP: begin
                    nx.stop_from_timeout = 1'b0;
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_SP_A;
                end
                i2cbe_pkg::OP_SEND: begin
                    nx.shift_reg = item.tx_byte;
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_TX_A;
                end
                i2cbe_pkg::OP_WAIT: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_WA_A;
                end
                i2cbe_pkg::OP_READ: begin
                    nx.shift_reg  = 8'd0;
                    nx.ack_choice = item.send_ack;
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_RX_A;
                end
                default: ;
            endcase
        end else if (st.phase == i2cbe_pkg::PH_WA_POLL) begin
            if (!item.sda_in) begin
                nx.scl         = 1'b0;
                nx.fail        = 1'b0;
                nx.phase       = i2cbe_pkg::PH_IDLE;
                nx.phase_timer = 4'd0;
                done           = 1'b1;
            end else if (st.poll_count >= cfg.ack_timeout) begin
                nx.stop_from_timeout = 1'b1;
                do_ent = 1'b1;
                ent    = i2cbe_pkg::PH_SP_A;
            end else begin
                nx.poll_count = st.poll_count + 8'd1;
            end
        end else if (st.phase_timer > 4'd1) begin
            nx.phase_timer = st.phase_timer - 4'd1;
        end else begin
            unique case (st.phase)
                i2cbe_pkg::PH_ST_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_ST_B;
                end
                i2cbe_pkg::PH_ST_B: begin
                    nx.scl = 1'b0;
                    done   = 1'b1;
                end
                i2cbe_pkg::PH_SP_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_SP_B;
                end
                i2cbe_pkg::PH_SP_B: begin
                    if (st.stop_from_timeout) begin
                        nx.fail              = 1'b1;
                        nx.stop_from_timeout = 1'b0;
                    end
                    done = 1'b1;
                end
                i2cbe_pkg::PH_TX_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_TX_B;
                end
                i2cbe_pkg::PH_TX_B: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_TX_C;
                end
                i2cbe_pkg::PH_TX_C: begin
                    nx.bit_index = bit_inc;
                    if (bit_inc < i2cbe_pkg::BITS_PER_BYTE) begin
                        do_ent = 1'b1;
                        ent    = i2cbe_pkg::PH_TX_A;
                    end else begin
                        done = 1'b1;
                    end
                end
                i2cbe_pkg::PH_WA_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_WA_B;
                end
                i2cbe_pkg::PH_WA_B: begin
                    nx.phase       = i2cbe_pkg::PH_WA_POLL;
                    nx.phase_timer = 4'd0;
                    nx.poll_count  = 8'd0;
                end
                i2cbe_pkg::PH_RX_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_RX_B;
                end
                i2cbe_pkg::PH_RX_B: begin
                    nx.bit_index = bit_inc;
                    do_ent = 1'b1;
                    ent    = (bit_inc < i2cbe_pkg::BITS_PER_BYTE) ?
                             i2cbe_pkg::PH_RX_A : i2cbe_pkg::PH_AK_A;
                end
                i2cbe_pkg::PH_AK_A: begin
                    do_ent = 1'b1;
                    ent    = i2cbe_pkg::PH_AK_B;
                end
                i2cbe_pkg::PH_AK_B: begin
                    nx.scl     = 1'b0;
                    nx.rx_last = st.shift_reg;
                    done       = 1'b1;
                end
                default: begin
                    nx.phase       = i2cbe_pkg::PH_IDLE;
                    nx.phase_timer = 4'd0;
                end
            endcase
            if (done) begin
                nx.phase       = i2cbe_pkg::PH_IDLE;
                nx.phase_timer = 4'd0;
            end
        end

        // Phase entry: drive the lines and load the hold timer.
        if (do_ent) begin
            nx.phase = ent;
            unique case (ent)
                i2cbe_pkg::PH_ST_A: begin nx.sda = 1'b1; nx.scl = 1'b1; end
                i2cbe_pkg::PH_ST_B: begin nx.sda = 1'b0; nx.scl = 1'b1; end
                i2cbe_pkg::PH_SP_A: begin nx.scl = 1'b0; nx.sda = 1'b0; end
                i2cbe_pkg::PH_SP_B: begin nx.scl = 1'b1; nx.sda = 1'b1; end
                i2cbe_pkg::PH_TX_A: begin
                    nx.sda       = nx.shift_reg[7];
                    nx.shift_reg = {nx.shift_reg[6:0], 1'b0};
                    nx.scl       = 1'b0;
                end
                i2cbe_pkg::PH_TX_B: nx.scl = 1'b1;
                i2cbe_pkg::PH_TX_C: nx.scl = 1'b0;
                i2cbe_pkg::PH_WA_A: nx.sda = 1'b1;
                i2cbe_pkg::PH_WA_B: nx.scl = 1'b1;
                i2cbe_pkg::PH_RX_A: begin nx.scl = 1'b0; nx.sda = 1'b1; end
                i2cbe_pkg::PH_RX_B: begin
                    nx.scl       = 1'b1;
                    nx.shift_reg = {nx.shift_reg[6:0], item.sda_in};
                end
                i2cbe_pkg::PH_AK_A: begin
                    nx.scl = 1'b0;
                    nx.sda = ~nx.ack_choice;
                end
                i2cbe_pkg::PH_AK_B: nx.scl = 1'b1;
                default: ;
            endcase
            if (ent == i2cbe_pkg::PH_ST_A || ent == i2cbe_pkg::PH_ST_B ||
                ent == i2cbe_pkg::PH_SP_A || ent == i2cbe_pkg::PH_SP_B) begin
                nx.phase_timer = i2cbe_pkg::hold_ticks(cfg.start_stop_hold);
            end else begin
                nx.phase_timer = i2cbe_pkg::hold_ticks(cfg.bit_phase_ticks);
            end
        end

        res.scl_level  = nx.scl;
        res.sda_level  = nx.sda;
        res.busy_res   = (nx.phase != i2cbe_pkg::PH_IDLE);
        res.done_res   = done;
        res.rx_byte    = nx.rx_last;
        res.ack_failed = nx.fail;
    end

endmodule

`default_nettype wire

### hw/rtl/i2cbe_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
`default_nettype none
`include "i2c_master_bit_engine_core_defines.svh"

module i2cbe_checker (
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       s_valid,
    input wire                       s_ready,
    input wire                       m_valid,
    input wire                       m_ready,
    input wire i2cbe_pkg::out_item_t m_data
);

    `I2CBE_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `I2CBE_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `I2CBE_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_valid && m_data.done_res, !m_data.busy_res)
    `I2CBE_ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `I2CBE_ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_data))

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_i2cbe_checker (.*);

`default_nettype wire
